@@ rtl/core/rc_pwm_four_channel_decoder_macros.svh @@
`ifndef RC_PWM_FOUR_CHANNEL_DECODER_MACROS_SVH
`define RC_PWM_FOUR_CHANNEL_DECODER_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define RCPWM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed by an outcome in the next cycle.
`define RCPWM_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/core/rcpwm_pkg.sv @@
package rcpwm_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int COUNT_WIDTH  = 16;
    localparam int CH_STICK     = 1;
    localparam int CH_LOSS      = 2;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef enum logic [2:0] {
        REG_WRAP_ADD      = 3'd0,
        REG_JUMP_LIMIT    = 3'd1,
        REG_JUMP_HOLD     = 3'd2,
        REG_STICK_THR     = 3'd3,
        REG_CONFIRM       = 3'd4,
        REG_LOSS_LIMIT    = 3'd5,
        REG_STARTUP_DELAY = 3'd6
    } t_reg_idx;

    localparam logic [15:0] RST_WRAP_ADD      = 16'd9999;
    localparam logic [15:0] RST_JUMP_LIMIT    = 16'd500;
    localparam logic [2:0]  RST_JUMP_HOLD     = 3'd5;
    localparam logic [15:0] RST_STICK_THR     = 16'd1600;
    localparam logic [15:0] RST_CONFIRM       = 16'd250;
    localparam logic [15:0] RST_LOSS_LIMIT    = 16'd100;
    localparam logic [31:0] RST_STARTUP_DELAY = 32'd0;

    localparam logic [15:0] STICK_HOLD_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] wrap_add;
        logic [15:0] jump_limit;
        logic [2:0]  jump_hold;
        logic [15:0] stick_thr;
        logic [15:0] confirm;
        logic [15:0] loss_limit;
        logic [31:0] startup_delay;
    } t_cfg;

    typedef struct packed {
        t_count width;
        logic   armed;
    } t_lane_out;

    typedef struct packed {
        t_count [NUM_CHANNELS-1:0] width;
        logic                      enter_rc_mode;
        logic                      clear_loss_count;
        logic [NUM_CHANNELS-1:0]   falling_armed;
    } t_result;

endpackage

@@ rtl/core/rcpwm_intf.sv @@
interface rcpwm_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  capture_flags;
    logic [15:0] count_ch1;
    logic [15:0] count_ch2;
    logic [15:0] count_ch3;
    logic [15:0] count_ch4;
    logic [15:0] loss_count;
    logic        rc_mode_active;
    logic [31:0] system_time;

    modport source (
        output valid, capture_flags, count_ch1, count_ch2, count_ch3, count_ch4,
               loss_count, rc_mode_active, system_time,
        input  ready
    );
    modport sink (
        input  valid, capture_flags, count_ch1, count_ch2, count_ch3, count_ch4,
               loss_count, rc_mode_active, system_time,
        output ready
    );
endinterface

interface rcpwm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] width_ch1;
    logic [15:0] width_ch2;
    logic [15:0] width_ch3;
    logic [15:0] width_ch4;
    logic        enter_rc_mode;
    logic        clear_loss_count;
    logic [3:0]  falling_armed;

    modport source (
        output valid, width_ch1, width_ch2, width_ch3, width_ch4, enter_rc_mode,
               clear_loss_count, falling_armed,
        input  ready
    );
    modport sink (
        input  valid, width_ch1, width_ch2, width_ch3, width_ch4, enter_rc_mode,
               clear_loss_count, falling_armed,
        output ready
    );
endinterface

@@ rtl/core/rcpwm_cfg.sv @@
module rcpwm_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rcpwm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rcpwm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rcpwm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output rcpwm_pkg::t_cfg                 o_cfg
);

    localparam int APB_IDX_HI = rcpwm_pkg::APB_ADDR_W - 1;

    rcpwm_pkg::t_cfg    r_cfg;
    rcpwm_pkg::t_cfg    n_cfg;
    rcpwm_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = rcpwm_pkg::t_reg_idx'(paddr[APB_IDX_HI:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                rcpwm_pkg::REG_WRAP_ADD:      n_cfg.wrap_add      = pwdata[15:0];
                rcpwm_pkg::REG_JUMP_LIMIT:    n_cfg.jump_limit    = pwdata[15:0];
                rcpwm_pkg::REG_JUMP_HOLD:     n_cfg.jump_hold     = pwdata[2:0];
                rcpwm_pkg::REG_STICK_THR:     n_cfg.stick_thr     = pwdata[15:0];
                rcpwm_pkg::REG_CONFIRM:       n_cfg.confirm       = pwdata[15:0];
                rcpwm_pkg::REG_LOSS_LIMIT:    n_cfg.loss_limit    = pwdata[15:0];
                rcpwm_pkg::REG_STARTUP_DELAY: n_cfg.startup_delay = pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            rcpwm_pkg::REG_WRAP_ADD:      prdata = {16'd0, r_cfg.wrap_add};
            rcpwm_pkg::REG_JUMP_LIMIT:    prdata = {16'd0, r_cfg.jump_limit};
            rcpwm_pkg::REG_JUMP_HOLD:     prdata = {29'd0, r_cfg.jump_hold};
            rcpwm_pkg::REG_STICK_THR:     prdata = {16'd0, r_cfg.stick_thr};
            rcpwm_pkg::REG_CONFIRM:       prdata = {16'd0, r_cfg.confirm};
            rcpwm_pkg::REG_LOSS_LIMIT:    prdata = {16'd0, r_cfg.loss_limit};
            rcpwm_pkg::REG_STARTUP_DELAY: prdata = r_cfg.startup_delay;
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wrap_add      <= rcpwm_pkg::RST_WRAP_ADD;
            r_cfg.jump_limit    <= rcpwm_pkg::RST_JUMP_LIMIT;
            r_cfg.jump_hold     <= rcpwm_pkg::RST_JUMP_HOLD;
            r_cfg.stick_thr     <= rcpwm_pkg::RST_STICK_THR;
            r_cfg.confirm       <= rcpwm_pkg::RST_CONFIRM;
            r_cfg.loss_limit    <= rcpwm_pkg::RST_LOSS_LIMIT;
            r_cfg.startup_delay <= rcpwm_pkg::RST_STARTUP_DELAY;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/core/rcpwm_lane.sv @@
module rcpwm_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_capture,
    input  rcpwm_pkg::t_count     i_count,
    input  rcpwm_pkg::t_cfg       i_cfg,
    output rcpwm_pkg::t_count     o_last_width,
    output rcpwm_pkg::t_lane_out  o_lane
);

    logic              r_awaiting;
    logic              n_awaiting;
    rcpwm_pkg::t_count r_rise;
    rcpwm_pkg::t_count n_rise;
    rcpwm_pkg::t_count r_last;
    rcpwm_pkg::t_count n_last;
    logic [2:0]        r_run;
    logic [2:0]        n_run;

    rcpwm_pkg::t_count w_raw;
    rcpwm_pkg::t_count w_width;
    rcpwm_pkg::t_count w_diff;
    logic [3:0]        w_run_inc;

    assign w_raw     = i_count - r_rise;
    assign w_width   = (i_count < r_rise)
                     ? rcpwm_pkg::t_count'(w_raw + i_cfg.wrap_add) : w_raw;
    assign w_diff    = (w_width > r_last) ? (w_width - r_last) : (r_last - w_width);
    assign w_run_inc = {1'b0, r_run} + 4'd1;

    always_comb begin
        n_awaiting = r_awaiting;
        n_rise     = r_rise;
        n_last     = r_last;
        n_run      = r_run;
        if (i_capture) begin
            if (r_awaiting) begin
                n_awaiting = 1'b0;
                n_last     = w_width;
                n_run      = '0;
                if (w_diff > rcpwm_pkg::t_count'(i_cfg.jump_limit)) begin
                    // spike: hold the previous width until the run runs out
                    if (w_run_inc <= {1'b0, i_cfg.jump_hold}) begin
                        n_run  = w_run_inc[2:0];
                        n_last = r_last;
                    end
                end
            end else begin
                n_rise     = i_count;
                n_awaiting = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_last     <= '0;
            r_run      <= '0;
        end else if (i_accept) begin
            r_awaiting <= n_awaiting;
            r_last     <= n_last;
            r_run      <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rise <= n_rise;
        end
    end

    assign o_last_width = r_last;
    assign o_lane.width = n_last;
    assign o_lane.armed = n_awaiting;

endmodule

@@ rtl/core/rcpwm_merge.sv @@
module rcpwm_merge (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_accept,
    input  rcpwm_pkg::t_lane_out [rcpwm_pkg::NUM_CHANNELS-1:0] i_lane,
    input  rcpwm_pkg::t_count                               i_stick_width,
    input  logic [rcpwm_pkg::NUM_CHANNELS-1:0]              i_capture_flags,
    input  logic [15:0]                                     i_loss_count,
    input  logic                                            i_rc_mode_active,
    input  logic [31:0]                                     i_system_time,
    input  rcpwm_pkg::t_cfg                                 i_cfg,
    output rcpwm_pkg::t_result                              o_word
);

    logic [15:0] r_stick_hold;
    logic [15:0] n_stick_hold;
    logic        w_stick_ok;
    logic        w_enter;

    assign w_stick_ok = (i_stick_width > rcpwm_pkg::t_count'(i_cfg.stick_thr))
                     && (i_loss_count < i_cfg.loss_limit)
                     && !i_rc_mode_active
                     && (i_system_time >= i_cfg.startup_delay);

    always_comb begin
        n_stick_hold = '0;
        w_enter      = 1'b0;
        if (w_stick_ok) begin
            n_stick_hold = (r_stick_hold == rcpwm_pkg::STICK_HOLD_MAX)
                         ? r_stick_hold : r_stick_hold + 16'd1;
            w_enter      = n_stick_hold > i_cfg.confirm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stick_hold <= '0;
        end else if (i_accept) begin
            r_stick_hold <= n_stick_hold;
        end
    end

    always_comb begin
        for (int i = 0; i < rcpwm_pkg::NUM_CHANNELS; i++) begin
            o_word.width[i]         = i_lane[i].width;
            o_word.falling_armed[i] = i_lane[i].armed;
        end
        o_word.enter_rc_mode    = w_enter;
        o_word.clear_loss_count = i_capture_flags[rcpwm_pkg::CH_LOSS];
    end

endmodule

@@ rtl/core/rc_pwm_four_channel_decoder.sv @@
// Channel   Direction  Handshake      Carries
// i_item    in         valid/ready    capture flags, four counts, loss, mode, time
// o_result  out        valid/ready    four widths, rc request, loss clear, armed
// apb       in/out     psel/penable   seven config registers at 4*index
//
// One word per cycle while i_item.ready is high: each word's lane update and result are registered when it is accepted.
// Result sits in an output register backed by a one-word skid register;
// i_item.ready drops only while the skid register holds a word.
// Synchronous active-low reset; rise counts are not reset.
module rc_pwm_four_channel_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rcpwm_in_if.sink                         i_item,
    rcpwm_out_if.source                      o_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rcpwm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rcpwm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rcpwm_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);

    rcpwm_pkg::t_cfg                                 w_cfg;
    rcpwm_pkg::t_count [rcpwm_pkg::NUM_CHANNELS-1:0] w_counts;
    rcpwm_pkg::t_count [rcpwm_pkg::NUM_CHANNELS-1:0] w_last;
    rcpwm_pkg::t_lane_out [rcpwm_pkg::NUM_CHANNELS-1:0] w_lane;
    rcpwm_pkg::t_result                              w_word;
    rcpwm_pkg::t_result                              r_out_word;
    rcpwm_pkg::t_result                              r_skid_word;
    logic                                            r_out_valid;
    logic                                            r_skid_valid;
    logic                                            w_accept;
    logic                                            w_out_fire;

    rcpwm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_counts[0] = i_item.count_ch1;
    assign w_counts[1] = i_item.count_ch2;
    assign w_counts[2] = i_item.count_ch3;
    assign w_counts[3] = i_item.count_ch4;

    assign i_item.ready = !r_skid_valid;
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_out_fire   = r_out_valid && o_result.ready;

    for (genvar g = 0; g < rcpwm_pkg::NUM_CHANNELS; g++) begin : g_lane
        rcpwm_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_accept     (w_accept),
            .i_capture    (i_item.capture_flags[g]),
            .i_count      (w_counts[g]),
            .i_cfg        (w_cfg),
            .o_last_width (w_last[g]),
            .o_lane       (w_lane[g])
        );
    end

    rcpwm_merge u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_lane           (w_lane),
        .i_stick_width    (w_last[rcpwm_pkg::CH_STICK]),
        .i_capture_flags  (i_item.capture_flags),
        .i_loss_count     (i_item.loss_count),
        .i_rc_mode_active (i_item.rc_mode_active),
        .i_system_time    (i_item.system_time),
        .i_cfg            (w_cfg),
        .o_word           (w_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            if (r_out_valid && !o_result.ready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (r_out_valid && !o_result.ready) begin
                r_skid_word <= w_word;
            end else begin
                r_out_word <= w_word;
            end
        end else if (w_out_fire && r_skid_valid) begin
            r_out_word <= r_skid_word;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.width_ch1        = r_out_word.width[0];
    assign o_result.width_ch2        = r_out_word.width[1];
    assign o_result.width_ch3        = r_out_word.width[2];
    assign o_result.width_ch4        = r_out_word.width[3];
    assign o_result.enter_rc_mode    = r_out_word.enter_rc_mode;
    assign o_result.clear_loss_count = r_out_word.clear_loss_count;
    assign o_result.falling_armed    = r_out_word.falling_armed;

    `include "rc_pwm_four_channel_decoder_macros.svh"

    `RCPWM_ASSERT_ALWAYS(a_skid_needs_out, !r_skid_valid || r_out_valid, "skid word without output word")
    `RCPWM_ASSERT_NEXT(a_stall_fills_skid, w_accept && r_out_valid && !o_result.ready, r_skid_valid, "stalled word not kept in skid")
    `RCPWM_ASSERT_NEXT(a_clear_tracks_ch3, w_accept && (!r_out_valid || o_result.ready), r_out_word.clear_loss_count == $past(i_item.capture_flags[rcpwm_pkg::CH_LOSS]), "loss clear does not follow channel three capture")

endmodule
